>>> src/periodic_job_dispatcher_assert.svh
// Assertion macros for the periodic job dispatcher.
`ifndef PERIODIC_JOB_DISPATCHER_ASSERT_SVH
`define PERIODIC_JOB_DISPATCHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PJD_ASSERT_IMPL(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define PJD_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define PJD_ASSERT_IMPL(label, cond)
`define PJD_ASSERT_NEXT(label, pre, post)
`endif
`endif

>>> src/pjd_pkg.sv
// ----------------------------------------------------------------------------
// Dispatcher package
// Shared constants and types of the periodic job dispatcher.
// ----------------------------------------------------------------------------
package pjd_pkg;

    localparam int NumSources = 256;
    localparam int QueueDepth = 64;
    localparam int SrcW = $clog2(NumSources);
    localparam int QW = $clog2(QueueDepth);

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_TICK = 2'd1,
        CMD_POP  = 2'd2,
        CMD_DONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_WORKERS  = 2'd0,
        REG_STAGGER  = 2'd1,
        REG_DEADLINE = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_DIV,
        ST_LOAD_MUL,
        ST_LOAD_WR,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_POP_RD,
        ST_POP_WR,
        ST_OUT
    } state_t;

endpackage

>>> src/pjd_queue.sv
// ----------------------------------------------------------------------------
// Dispatch queue
// Circular buffer of source indexes with registered read data.
// ----------------------------------------------------------------------------
module pjd_queue
    import pjd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [SrcW-1:0]     push_data,
    input  logic                pop,
    output logic [SrcW-1:0]     head_data,
    output logic [QW:0]         fill
);

    logic [SrcW-1:0] mem [QueueDepth];
    logic [QW-1:0]   head_reg, head_next, tail_reg, tail_next;
    logic [QW:0]     fill_reg, fill_next;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (push)
        begin
            tail_next = (tail_reg == QW'(QueueDepth - 1)) ? '0 : tail_reg + 1'b1;
            fill_next = fill_next + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == QW'(QueueDepth - 1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_data;
        end
        head_data <= mem[head_reg];
    end

    assign fill = fill_reg;

endmodule

>>> src/periodic_job_dispatcher.sv
// Path to the result: done and empty pop go straight to ST_OUT, pop through
// ST_POP_RD/ST_POP_WR, load through ST_LOAD_DIV/MUL/WR, tick through ST_SCAN_RD/EV
// per source. One transaction at a time; the load divides by repeated subtraction
// and the tick scan reads one source at a time through a single compare/add unit.
// The result is held until taken; the next item is accepted in the cycle after it is taken.
// Reset (rst_n, asynchronous) clears time, queue, flags and counters; the
// per-source tables are covered by valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Periodic job dispatcher
// Per-source scheduler with a bounded dedup FIFO, sequenced over the sources.
// ----------------------------------------------------------------------------
`include "periodic_job_dispatcher_assert.svh"
module periodic_job_dispatcher
    import pjd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: source_index[7:0], interval_sec[31:8], on_demand[32],
    // quarantined[33], zero pad [39:34]
    input  logic [39:0] s_axis_tdata,
    // tuser: command[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: popped_index[7:0], pushed_count[16:8], dropped_count[25:17],
    // overdue_count[34:26], queued_count[41:35], busy_count[50:42],
    // total_dropped[66:51], zero pad [71:67]
    output logic [71:0] m_axis_tdata,
    // tuser: popped_valid[0]
    output logic        m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    state_t state_reg, state_next;

    logic [5:0]  workers_reg;
    logic [7:0]  stagger_reg;
    logic [15:0] deadline_reg;
    logic [31:0] time_reg;
    logic [15:0] drop_reg;

    logic [SrcW-1:0] idx_reg;
    logic [23:0]     ival_reg;
    logic [1:0]      mode_in_reg;

    logic [23:0] ival_mem [NumSources];
    logic [31:0] due_mem  [NumSources];
    logic [1:0]  mode_mem [NumSources];
    logic [31:0] start_mem [NumSources];
    logic [NumSources-1:0] valid_bits_reg, pending_reg, inflight_reg;

    logic [23:0] rd_ival;
    logic [31:0] rd_due, rd_start;
    logic [1:0]  rd_mode;

    logic [SrcW-1:0] scan_reg;
    logic [SrcW:0]   quot_reg;
    logic [5:0]      wcl;
    logic [SrcW+7:0] prod_reg;
    logic [8:0] pushed_reg, dropped_reg, overdue_reg, busy_reg;
    logic       pv_reg;
    logic [SrcW-1:0] pidx_reg;

    logic            q_push, q_pop;
    logic [SrcW-1:0] q_head;
    logic [QW:0]     q_fill;

    logic        ent_valid, due_hit, offer_ok, in_acc, out_acc;
    logic [31:0] elapsed;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign wcl = (workers_reg == 6'd0) ? 6'd1 : (workers_reg > 6'd32) ? 6'd32 : workers_reg;
    assign ent_valid = valid_bits_reg[scan_reg];
    assign due_hit = ent_valid && (rd_ival != 24'd0) && (time_reg >= rd_due);
    assign offer_ok = due_hit && (rd_mode == 2'b00) && !pending_reg[scan_reg];
    assign elapsed = time_reg - rd_start;

    pjd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (scan_reg),
        .pop       (q_pop),
        .head_data (q_head),
        .fill      (q_fill)
    );

    assign q_push = (state_reg == ST_SCAN_EV) && offer_ok && (q_fill != (QW+1)'(QueueDepth));
    assign q_pop  = (state_reg == ST_POP_WR);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (s_axis_tuser)
                        CMD_LOAD: state_next = ST_LOAD_DIV;
                        CMD_TICK: state_next = ST_SCAN_RD;
                        CMD_POP:  state_next = (q_fill == '0) ? ST_OUT : ST_POP_RD;
                        default:  state_next = ST_OUT;
                    endcase
                end
            end
            ST_LOAD_DIV: state_next = (quot_reg < {3'b0, wcl}) ? ST_LOAD_MUL : ST_LOAD_DIV;
            ST_LOAD_MUL: state_next = ST_LOAD_WR;
            ST_LOAD_WR:  state_next = ST_OUT;
            ST_SCAN_RD:  state_next = ST_SCAN_EV;
            ST_SCAN_EV:  state_next = (scan_reg == SrcW'(NumSources - 1)) ? ST_OUT : ST_SCAN_RD;
            ST_POP_RD:   state_next = ST_POP_WR;
            ST_POP_WR:   state_next = ST_OUT;
            ST_OUT:      state_next = out_acc ? ST_IDLE : ST_OUT;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        m_axis_tvalid = (state_reg == ST_OUT);
        cfg_ready = 1'b1;
    end

    // Division by repeated subtraction: quot_reg carries the remainder and
    // prod_reg the quotient during ST_LOAD_DIV.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_acc)
        begin
            idx_reg     <= s_axis_tdata[7:0];
            ival_reg    <= s_axis_tdata[31:8];
            mode_in_reg <= {s_axis_tdata[33], s_axis_tdata[32]};
            quot_reg    <= {1'b0, s_axis_tdata[7:0]};
            prod_reg    <= '0;
        end
        else if (state_reg == ST_LOAD_DIV)
        begin
            if (quot_reg >= {3'b0, wcl})
            begin
                quot_reg <= quot_reg - {3'b0, wcl};
                prod_reg <= prod_reg + 1'b1;
            end
        end
        else if (state_reg == ST_LOAD_MUL)
        begin
            prod_reg <= prod_reg[SrcW-1:0] * stagger_reg;
        end
        rd_ival  <= ival_mem[scan_reg];
        rd_due   <= due_mem[scan_reg];
        rd_mode  <= mode_mem[scan_reg];
        rd_start <= start_mem[state_reg == ST_POP_WR ? q_head : scan_reg];
        if (state_reg == ST_LOAD_WR)
        begin
            ival_mem[idx_reg] <= ival_reg;
            mode_mem[idx_reg] <= mode_in_reg;
            due_mem[idx_reg]  <= time_reg + {16'b0, prod_reg};
        end
        else if (state_reg == ST_SCAN_EV && due_hit)
        begin
            due_mem[scan_reg] <= time_reg + {8'b0, rd_ival};
        end
        if (state_reg == ST_POP_WR)
        begin
            start_mem[q_head] <= time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            workers_reg    <= 6'd8;
            stagger_reg    <= 8'd3;
            deadline_reg   <= 16'd300;
            time_reg       <= '0;
            drop_reg       <= '0;
            valid_bits_reg <= '0;
            pending_reg    <= '0;
            inflight_reg   <= '0;
            scan_reg       <= '0;
            pushed_reg     <= '0;
            dropped_reg    <= '0;
            overdue_reg    <= '0;
            busy_reg       <= '0;
            pv_reg         <= 1'b0;
            pidx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WORKERS:  workers_reg  <= cfg_data[5:0];
                    REG_STAGGER:  stagger_reg  <= cfg_data[7:0];
                    REG_DEADLINE: deadline_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_IDLE && in_acc)
            begin
                pushed_reg  <= '0;
                dropped_reg <= '0;
                overdue_reg <= '0;
                pv_reg      <= 1'b0;
                pidx_reg    <= '0;
                scan_reg    <= '0;
                if (s_axis_tuser == CMD_TICK)
                begin
                    time_reg <= time_reg + 1'b1;
                end
                if (s_axis_tuser == CMD_DONE && inflight_reg[s_axis_tdata[7:0]])
                begin
                    inflight_reg[s_axis_tdata[7:0]] <= 1'b0;
                    pending_reg[s_axis_tdata[7:0]]  <= 1'b0;
                    busy_reg <= busy_reg - 1'b1;
                end
            end
            if (state_reg == ST_LOAD_WR)
            begin
                valid_bits_reg[idx_reg] <= 1'b1;
            end
            if (state_reg == ST_SCAN_EV)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (offer_ok)
                begin
                    if (q_push)
                    begin
                        pending_reg[scan_reg] <= 1'b1;
                        pushed_reg <= pushed_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_reg <= dropped_reg + 1'b1;
                        if (drop_reg != 16'hFFFF)
                        begin
                            drop_reg <= drop_reg + 1'b1;
                        end
                    end
                end
                if (deadline_reg != 16'd0 && inflight_reg[scan_reg]
                    && elapsed > {16'b0, deadline_reg})
                begin
                    overdue_reg <= overdue_reg + 1'b1;
                end
            end
            if (state_reg == ST_POP_WR)
            begin
                pv_reg   <= 1'b1;
                pidx_reg <= q_head;
                if (!inflight_reg[q_head])
                begin
                    busy_reg <= busy_reg + 1'b1;
                end
                inflight_reg[q_head] <= 1'b1;
            end
        end
    end

    assign m_axis_tuser = pv_reg;
    assign m_axis_tdata = {5'b0, drop_reg, busy_reg, q_fill, overdue_reg,
                           dropped_reg, pushed_reg, pidx_reg};

    `PJD_ASSERT_IMPL(a_busy_count, busy_reg == 9'($countones(inflight_reg)))
    `PJD_ASSERT_IMPL(a_fill_range, q_fill <= (QW+1)'(QueueDepth))
    `PJD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `PJD_ASSERT_IMPL(a_push_full, !(q_push && q_fill == (QW+1)'(QueueDepth)))

endmodule

>>> tb/sv/tb_periodic_job_dispatcher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic job dispatcher testbench
// Drives load, tick, pop and done commands through the input stream. A local
// scheduler model predicts every result, and each result is checked against it.
// Register settings, stalls on both streams and a long output hold-off vary
// across the run.
// ----------------------------------------------------------------------------
module tb_periodic_job_dispatcher;
    import pjd_pkg::*;

    typedef struct packed {
        logic        valid;
        logic [7:0]  index;
        logic [8:0]  pushed;
        logic [8:0]  dropped;
        logic [8:0]  overdue;
        logic [6:0]  queued;
        logic [8:0]  busy;
        logic [15:0] drop_total;
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = CMD_LOAD;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_WORKERS;
    logic [15:0] cfg_data = '0;

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int mismatches = 0;
    int reports_checked = 0;
    int cmd_seen [4] = '{0, 0, 0, 0};
    int pops_hit = 0;
    int drops_seen = 0;
    int overdue_seen = 0;

    report_t expected_reports [$];

    logic [5:0]  cfg_workers;
    logic [7:0]  cfg_stagger;
    logic [15:0] cfg_deadline;
    logic [31:0] now_sec;
    logic [23:0] period_tab [NumSources];
    logic [31:0] due_tab [NumSources];
    logic [1:0]  mode_tab [NumSources];
    logic        queued_flag [NumSources];
    logic        running_flag [NumSources];
    logic [31:0] started_tab [NumSources];
    logic [7:0]  fifo_mem [QueueDepth];
    int          fifo_rd;
    int          fifo_wr;
    int          fifo_cnt;
    int          drop_sum;

    periodic_job_dispatcher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    function automatic void sched_reset();
        cfg_workers = 6'd8;
        cfg_stagger = 8'd3;
        cfg_deadline = 16'd300;
        now_sec = '0;
        for (int i = 0; i < NumSources; i++)
        begin
            period_tab[i] = '0;
            due_tab[i] = '0;
            mode_tab[i] = '0;
            queued_flag[i] = 1'b0;
            running_flag[i] = 1'b0;
            started_tab[i] = '0;
        end
        fifo_rd = 0;
        fifo_wr = 0;
        fifo_cnt = 0;
        drop_sum = 0;
    endfunction

    function automatic report_t sched_step(cmd_t cmd, logic [7:0] idx, logic [23:0] period,
                                           logic so, logic qu);
        report_t r;
        int groups;
        r = '0;
        case (cmd)
            CMD_LOAD:
            begin
                groups = (cfg_workers == 0) ? 1 : (cfg_workers > 32) ? 32 : cfg_workers;
                period_tab[idx] = period;
                mode_tab[idx] = {qu, so};
                due_tab[idx] = now_sec + 32'((idx / groups) * cfg_stagger);
            end
            CMD_TICK:
            begin
                now_sec = now_sec + 1;
                for (int i = 0; i < NumSources; i++)
                begin
                    if (period_tab[i] != 0 && now_sec >= due_tab[i])
                    begin
                        due_tab[i] = now_sec + 32'(period_tab[i]);
                        if (mode_tab[i] == 0 && !queued_flag[i])
                        begin
                            if (fifo_cnt >= QueueDepth)
                            begin
                                if (drop_sum < 65535)
                                    drop_sum++;
                                r.dropped++;
                            end
                            else
                            begin
                                queued_flag[i] = 1'b1;
                                fifo_mem[fifo_wr] = 8'(i);
                                fifo_wr = (fifo_wr + 1) % QueueDepth;
                                fifo_cnt++;
                                r.pushed++;
                            end
                        end
                    end
                end
                if (cfg_deadline != 0)
                    for (int i = 0; i < NumSources; i++)
                        if (running_flag[i] && (now_sec - started_tab[i]) > cfg_deadline)
                            r.overdue++;
            end
            CMD_POP:
            begin
                if (fifo_cnt > 0)
                begin
                    r.valid = 1'b1;
                    r.index = fifo_mem[fifo_rd];
                    fifo_rd = (fifo_rd + 1) % QueueDepth;
                    fifo_cnt--;
                    running_flag[r.index] = 1'b1;
                    started_tab[r.index] = now_sec;
                end
            end
            default:
            begin
                if (running_flag[idx])
                begin
                    running_flag[idx] = 1'b0;
                    queued_flag[idx] = 1'b0;
                end
            end
        endcase
        r.queued = 7'(fifo_cnt);
        for (int i = 0; i < NumSources; i++)
            r.busy += running_flag[i];
        r.drop_total = 16'(drop_sum);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        report_t got;
        report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.valid = m_axis_tuser;
            got.index = m_axis_tdata[7:0];
            got.pushed = m_axis_tdata[16:8];
            got.dropped = m_axis_tdata[25:17];
            got.overdue = m_axis_tdata[34:26];
            got.queued = m_axis_tdata[41:35];
            got.busy = m_axis_tdata[50:42];
            got.drop_total = m_axis_tdata[66:51];
            reports_checked++;
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction at %0t: %p", $time, got);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.valid != want.valid || got.index != want.index
                    || got.pushed != want.pushed || got.dropped != want.dropped
                    || got.overdue != want.overdue || got.queued != want.queued
                    || got.busy != want.busy || got.drop_total != want.drop_total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: expected %p, actual %p", $time, want, got);
                end
            end
        end
    end

    task automatic send_item(cmd_t cmd, logic [7:0] idx, logic [23:0] period, logic so,
                             logic qu);
        report_t r;
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {6'b0, qu, so, period, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = sched_step(cmd, idx, period, so, qu);
        expected_reports.push_back(r);
        cmd_seen[cmd]++;
        pops_hit += r.valid;
        drops_seen += r.dropped;
        overdue_seen += r.overdue;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WORKERS:  cfg_workers = value[5:0];
            REG_STAGGER:  cfg_stagger = value[7:0];
            default:      cfg_deadline = value;
        endcase
    endtask

    task automatic set_regs(logic [15:0] workers, logic [15:0] stagger, logic [15:0] deadline);
        drain();
        write_reg(REG_WORKERS, workers);
        write_reg(REG_STAGGER, stagger);
        write_reg(REG_DEADLINE, deadline);
    endtask

    task automatic test_directed();
        send_item(CMD_POP, 8'd0, 24'd0, 1'b0, 1'b0);
        send_item(CMD_DONE, 8'd7, 24'd0, 1'b0, 1'b0);
        send_item(CMD_LOAD, 8'd0, 24'd1, 1'b0, 1'b0);
        send_item(CMD_LOAD, 8'd255, 24'hFFFFFF, 1'b0, 1'b0);
        send_item(CMD_LOAD, 8'd1, 24'd0, 1'b0, 1'b0);
        send_item(CMD_LOAD, 8'd2, 24'd1, 1'b1, 1'b0);
        send_item(CMD_LOAD, 8'd3, 24'd2, 1'b0, 1'b1);
        send_item(CMD_LOAD, 8'd4, 24'd1, 1'b1, 1'b1);
        send_item(CMD_TICK, 8'd0, 24'd0, 1'b0, 1'b0);
        send_item(CMD_TICK, 8'd0, 24'd0, 1'b0, 1'b0);
        send_item(CMD_POP, 8'd0, 24'd0, 1'b0, 1'b0);
        send_item(CMD_TICK, 8'd0, 24'd0, 1'b0, 1'b0);
        send_item(CMD_POP, 8'd0, 24'd0, 1'b0, 1'b0);
        send_item(CMD_LOAD, 8'd0, 24'd3, 1'b0, 1'b0);
        send_item(CMD_DONE, 8'd0, 24'd0, 1'b0, 1'b0);
        send_item(CMD_DONE, 8'd0, 24'd0, 1'b0, 1'b0);
        send_item(CMD_TICK, 8'd0, 24'd0, 1'b0, 1'b0);
        send_item(CMD_POP, 8'd0, 24'd0, 1'b0, 1'b0);
    endtask

    task automatic test_backpressure();
        hold_left <= 400;
        for (int i = 0; i < 8; i++)
            send_item(CMD_LOAD, 8'(i + 16), 24'd1, 1'b0, 1'b0);
    endtask

    task automatic random_item();
        int pick;
        int idx;
        logic [23:0] period;
        pick = $urandom_range(99);
        if (pick < 32)
        begin
            case ($urandom_range(9))
                0:       period = 24'd0;
                1:       period = 24'($urandom);
                2:       period = 24'hFFFFFF;
                default: period = 24'($urandom_range(6, 1));
            endcase
            send_item(CMD_LOAD, 8'($urandom), period, $urandom_range(9) == 0,
                      $urandom_range(9) == 0);
        end
        else if (pick < 47)
            send_item(CMD_TICK, 8'($urandom), 24'($urandom), 1'($urandom), 1'($urandom));
        else if (pick < 75)
            send_item(CMD_POP, 8'($urandom), 24'($urandom), 1'($urandom), 1'($urandom));
        else
        begin
            idx = $urandom_range(NumSources - 1);
            if ($urandom_range(9) != 0)
                for (int k = 0; k < NumSources; k++)
                    if (running_flag[(idx + k) % NumSources])
                    begin
                        idx = (idx + k) % NumSources;
                        break;
                    end
            send_item(CMD_DONE, 8'(idx), 24'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            random_item();
    endtask

    initial
    begin
        sched_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();

        send_gap_pct = 15;
        recv_stall_pct = 49;
        set_regs(16'd0, 16'd0, 16'd2);
        test_random(260);
        set_regs(16'd63, 16'd255, 16'd65535);
        test_random(260);

        send_gap_pct = 49;
        recv_stall_pct = 15;
        set_regs(16'd32, 16'd1, 16'd0);
        test_random(260);
        set_regs(16'd1, 16'd0, 16'd5);
        test_random(260);

        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_regs(16'd5, 16'd2, 16'd1);
        test_random(260);
        set_regs(16'hFFC8, 16'hFF03, 16'd300);
        test_random(260);

        s_axis_tvalid <= 1'b0;
        for (int w = 0; w < 100000 && expected_reports.size() != 0; w++)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (expected_reports.size() != 0)
            mismatches++;

        $display("covered %0d loads, %0d ticks, %0d pops (%0d hit), %0d dones",
                 cmd_seen[CMD_LOAD], cmd_seen[CMD_TICK], cmd_seen[CMD_POP], pops_hit,
                 cmd_seen[CMD_DONE]);
        $display("checked %0d results, %0d drops, %0d overdue counts, %0d mismatches",
                 reports_checked, drops_seen, overdue_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
